### src/clipped_pixmap_blit_top_macros.svh
// ----------------------------------------------------------------------------
// Clipped pixmap blit assertion macros
// Shared concurrent assertion forms used by the blit datapath.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_PIXMAP_BLIT_TOP_MACROS_SVH
`define CLIPPED_PIXMAP_BLIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cpb_pkg.sv
// ----------------------------------------------------------------------------
// Clipped pixmap blit package
// Shared constants, register indexes and interface types of the blit.
// ----------------------------------------------------------------------------
package cpb_pkg;

	localparam int MAX_WIDTH_DEF  = 8;
	localparam int MAX_HEIGHT_DEF = 8;

	localparam logic [2:0] REG_PIXMAP_WIDTH  = 3'd0;
	localparam logic [2:0] REG_PIXMAP_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ANCHOR_X      = 3'd2;
	localparam logic [2:0] REG_ANCHOR_Y      = 3'd3;
	localparam logic [2:0] REG_CLIP_XMIN     = 3'd4;
	localparam logic [2:0] REG_CLIP_XMAX     = 3'd5;
	localparam logic [2:0] REG_CLIP_YMIN     = 3'd6;
	localparam logic [2:0] REG_CLIP_YMAX     = 3'd7;

	localparam logic [1:0] CODE_FG = 2'd1;
	localparam logic [1:0] CODE_BG = 2'd2;

	localparam logic REQ_DRAW = 1'b1;

	typedef struct packed {
		logic [3:0]  pixmap_width;
		logic [3:0]  pixmap_height;
		logic [2:0]  anchor_x;
		logic [2:0]  anchor_y;
		logic [10:0] clip_xmin;
		logic [10:0] clip_xmax;
		logic [10:0] clip_ymin;
		logic [10:0] clip_ymax;
	} cfg_t;

	typedef struct packed {
		logic clr_step;
		logic set_wr;
		logic load;
		logic scan_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic scan_last;
		logic pix_empty;
	} status_t;

endpackage

### src/cpb_regs.sv
// ----------------------------------------------------------------------------
// Clipped pixmap blit configuration registers
// APB-style register file holding pixmap geometry, anchor and clip window.
// ----------------------------------------------------------------------------
module cpb_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output cpb_pkg::cfg_t cfg
);

	cpb_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixmap_width  <= 4'd8;
			cfg_q.pixmap_height <= 4'd8;
			cfg_q.anchor_x      <= 3'd4;
			cfg_q.anchor_y      <= 3'd4;
			cfg_q.clip_xmin     <= 11'd0;
			cfg_q.clip_xmax     <= 11'd2047;
			cfg_q.clip_ymin     <= 11'd0;
			cfg_q.clip_ymax     <= 11'd2047;
		end else if (wr_en) begin
			unique case (reg_idx)
				cpb_pkg::REG_PIXMAP_WIDTH:  cfg_q.pixmap_width  <= pwdata[3:0];
				cpb_pkg::REG_PIXMAP_HEIGHT: cfg_q.pixmap_height <= pwdata[3:0];
				cpb_pkg::REG_ANCHOR_X:      cfg_q.anchor_x      <= pwdata[2:0];
				cpb_pkg::REG_ANCHOR_Y:      cfg_q.anchor_y      <= pwdata[2:0];
				cpb_pkg::REG_CLIP_XMIN:     cfg_q.clip_xmin     <= pwdata[10:0];
				cpb_pkg::REG_CLIP_XMAX:     cfg_q.clip_xmax     <= pwdata[10:0];
				cpb_pkg::REG_CLIP_YMIN:     cfg_q.clip_ymin     <= pwdata[10:0];
				cpb_pkg::REG_CLIP_YMAX:     cfg_q.clip_ymax     <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			cpb_pkg::REG_PIXMAP_WIDTH:  prdata = {28'd0, cfg_q.pixmap_width};
			cpb_pkg::REG_PIXMAP_HEIGHT: prdata = {28'd0, cfg_q.pixmap_height};
			cpb_pkg::REG_ANCHOR_X:      prdata = {29'd0, cfg_q.anchor_x};
			cpb_pkg::REG_ANCHOR_Y:      prdata = {29'd0, cfg_q.anchor_y};
			cpb_pkg::REG_CLIP_XMIN:     prdata = {21'd0, cfg_q.clip_xmin};
			cpb_pkg::REG_CLIP_XMAX:     prdata = {21'd0, cfg_q.clip_xmax};
			cpb_pkg::REG_CLIP_YMIN:     prdata = {21'd0, cfg_q.clip_ymin};
			cpb_pkg::REG_CLIP_YMAX:     prdata = {21'd0, cfg_q.clip_ymax};
		endcase
	end

endmodule

### src/cpb_ctrl.sv
// ----------------------------------------------------------------------------
// Clipped pixmap blit controller
// Sequences the clearing pass, set requests and the draw scan.
// ----------------------------------------------------------------------------
module cpb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             req_type,
	input  cpb_pkg::status_t status,
	output cpb_pkg::cmd_t    cmd,
	output logic             busy
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (req_type == cpb_pkg::REQ_DRAW) begin
						cmd.load = 1'b1;
						state_d  = status.pix_empty ? ST_FIN : ST_SCAN;
					end else begin
						cmd.set_wr = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/cpb_dp.sv
// ----------------------------------------------------------------------------
// Clipped pixmap blit datapath
// Pixmap memory, scan counters, clip test, pending write and result register.
// ----------------------------------------------------------------------------
module cpb_dp #(
	parameter int MAX_WIDTH  = cpb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cpb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cpb_pkg::cfg_t       cfg,
	input  cpb_pkg::cmd_t       cmd,
	output cpb_pkg::status_t    status,
	input  logic signed [11:0]  pos_x,
	input  logic signed [11:0]  pos_y,
	input  logic [1:0]          pixel_code,
	input  logic [7:0]          fg_color,
	input  logic [7:0]          bg_color,
	output logic                result_strobe,
	output logic                write_valid,
	output logic [10:0]         fb_x,
	output logic [10:0]         fb_y,
	output logic [7:0]          color,
	output logic                last
);

	`include "clipped_pixmap_blit_top_macros.svh"

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int IW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int WCAP        = (MAX_WIDTH > 15) ? 15 : MAX_WIDTH;
	localparam int HCAP        = (MAX_HEIGHT > 15) ? 15 : MAX_HEIGHT;

	logic [1:0]          mem [STORE_DEPTH];

	logic [3:0]          w_eff;
	logic [3:0]          h_eff;
	logic [IW-1:0]       clr_q;
	logic [3:0]          r_q;
	logic [3:0]          c_q;
	logic [IW-1:0]       idx_q;
	logic signed [12:0]  left_q;
	logic signed [12:0]  top_q;
	logic [7:0]          fg_q;
	logic [7:0]          bg_q;

	logic                set_ok;
	logic [7:0]          set_idx;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [1:0]          mem_wdata;

	logic signed [13:0]  fx;
	logic signed [13:0]  fy;
	logic                vis;

	logic                valid_s1;
	logic                vis_s1;
	logic [10:0]         fx_s1;
	logic [10:0]         fy_s1;
	logic [1:0]          code_s1;

	logic                hit;
	logic [7:0]          hit_color;
	logic                emit_mid;

	logic                pend_q;
	logic [10:0]         pend_x_q;
	logic [10:0]         pend_y_q;
	logic [7:0]          pend_color_q;

	logic                out_stb_q;
	logic                out_wv_q;
	logic [10:0]         out_x_q;
	logic [10:0]         out_y_q;
	logic [7:0]          out_color_q;
	logic                out_last_q;

	assign w_eff = (cfg.pixmap_width > 4'(WCAP)) ? 4'(WCAP) : cfg.pixmap_width;
	assign h_eff = (cfg.pixmap_height > 4'(HCAP)) ? 4'(HCAP) : cfg.pixmap_height;

	assign status.clr_done  = (clr_q == IW'(STORE_DEPTH - 1));
	assign status.scan_last = (r_q == h_eff - 4'd1) && (c_q == w_eff - 4'd1);
	assign status.pix_empty = (w_eff == 4'd0) || (h_eff == 4'd0);

	assign set_ok = !pos_x[11] && (pos_x[10:4] == 7'd0) && (pos_x[3:0] < w_eff) &&
		!pos_y[11] && (pos_y[10:4] == 7'd0) && (pos_y[3:0] < h_eff);
	assign set_idx = w_eff * pos_y[3:0] + {4'd0, pos_x[3:0]};

	assign mem_we    = cmd.clr_step | (cmd.set_wr & set_ok);
	assign mem_waddr = cmd.clr_step ? clr_q : IW'(set_idx);
	assign mem_wdata = cmd.clr_step ? 2'd0 : pixel_code;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		code_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q    <= 4'd0;
			c_q    <= 4'd0;
			idx_q  <= '0;
			left_q <= $signed({pos_x[11], pos_x}) - $signed({10'd0, cfg.anchor_x});
			top_q  <= $signed({pos_y[11], pos_y}) + $signed({10'd0, cfg.anchor_y});
			fg_q   <= fg_color;
			bg_q   <= bg_color;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + IW'(1);
			if (c_q == w_eff - 4'd1) begin
				c_q <= 4'd0;
				r_q <= r_q + 4'd1;
			end else begin
				c_q <= c_q + 4'd1;
			end
		end
	end

	assign fx  = $signed({left_q[12], left_q}) + $signed({10'd0, c_q});
	assign fy  = $signed({top_q[12], top_q}) - $signed({10'd0, r_q});
	assign vis = (fx >= $signed({3'd0, cfg.clip_xmin})) && (fx < $signed({3'd0, cfg.clip_xmax})) &&
		(fy >= $signed({3'd0, cfg.clip_ymin})) && (fy < $signed({3'd0, cfg.clip_ymax}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		vis_s1 <= vis;
		fx_s1  <= fx[10:0];
		fy_s1  <= fy[10:0];
	end

	assign hit       = valid_s1 && vis_s1 && (code_s1 == cpb_pkg::CODE_FG ||
		code_s1 == cpb_pkg::CODE_BG);
	assign hit_color = (code_s1 == cpb_pkg::CODE_FG) ? fg_q : bg_q;
	assign emit_mid  = hit & pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.load) begin
			pend_q <= 1'b0;
		end else if (hit) begin
			pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			pend_x_q     <= fx_s1;
			pend_y_q     <= fy_s1;
			pend_color_q <= hit_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stb_q <= 1'b0;
		end else begin
			out_stb_q <= emit_mid | cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_wv_q    <= pend_q;
			out_x_q     <= pend_q ? pend_x_q : 11'd0;
			out_y_q     <= pend_q ? pend_y_q : 11'd0;
			out_color_q <= pend_q ? pend_color_q : 8'd0;
			out_last_q  <= 1'b1;
		end else if (emit_mid) begin
			out_wv_q    <= 1'b1;
			out_x_q     <= pend_x_q;
			out_y_q     <= pend_y_q;
			out_color_q <= pend_color_q;
			out_last_q  <= 1'b0;
		end
	end

	assign result_strobe = out_stb_q;
	assign write_valid   = out_wv_q;
	assign fb_x          = out_x_q;
	assign fb_y          = out_y_q;
	assign color         = out_color_q;
	assign last          = out_last_q;

	`CPB_ASSERT_NEXT(a_mid_emit, emit_mid && !cmd.fin, out_stb_q && !out_last_q,
		"A displaced pending write was not emitted as a non-final result.")
	`CPB_ASSERT_NEXT(a_fin_last, cmd.fin, out_stb_q && out_last_q,
		"The end of a draw did not produce a final result.")
	`CPB_ASSERT_IMPL(a_empty_zero, out_stb_q && !out_wv_q,
		out_last_q && out_x_q == 11'd0 && out_y_q == 11'd0 && out_color_q == 8'd0,
		"An empty result is not a zeroed final result.")

endmodule

### src/clipped_pixmap_blit_top.sv
// ----------------------------------------------------------------------------
// Clipped pixmap blit top level
// Stores a small pixmap of 2-bit codes and draws it clipped onto a framebuffer.
// ----------------------------------------------------------------------------
// A request is accepted on a rising edge with start high and busy low.
// A set request (req_type 0) stores pixel_code at pixmap cell (pos_x, pos_y)
// in that cycle and gives no result; busy stays low, so sets may follow in
// every cycle. A draw request (req_type 1) scans every cell of the pixmap in
// use, one cell per cycle through the pixmap memory read port, and emits one
// framebuffer write transaction per visible foreground or background cell,
// rows from top to bottom and columns left to right. Each result is shown for
// one cycle with result_strobe high; the receiver cannot stall it. The final
// result of a draw carries last; a draw that writes nothing gives one result
// with write_valid low and last high. A draw holds busy through the scan
// state, a drain state and a final state (the final state alone for an empty
// pixmap); its final result appears in the cycle busy falls. After reset the
// whole pixmap memory is cleared with busy high; register writes on the
// APB-style port are taken at any time and should be made while busy is low.
// ----------------------------------------------------------------------------
module clipped_pixmap_blit_top #(
	parameter int MAX_WIDTH  = cpb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cpb_pkg::MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic [1:0]         pixel_code,
	input  logic [7:0]         fg_color,
	input  logic [7:0]         bg_color,
	output logic               result_strobe,
	output logic               write_valid,
	output logic [10:0]        fb_x,
	output logic [10:0]        fb_y,
	output logic [7:0]         color,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cpb_pkg::cfg_t    cfg;
	cpb_pkg::cmd_t    cmd;
	cpb_pkg::status_t status;

	cpb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	cpb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pixel_code    (pixel_code),
		.fg_color      (fg_color),
		.bg_color      (bg_color),
		.result_strobe (result_strobe),
		.write_valid   (write_valid),
		.fb_x          (fb_x),
		.fb_y          (fb_y),
		.color         (color),
		.last          (last)
	);

endmodule
